@@ rtl/crd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crd_pkg
// Shared widths, register map, reset values and pipeline transfer structs of
// the camera ray direction core.
// ----------------------------------------------------------------------------
package crd_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS = 16;
    localparam int UNIT      = 1 << FRAC_BITS;
    localparam int COORD_W   = 16;
    localparam int COMP_W    = 18;
    localparam int BASIS_W   = 3 * COMP_W;
    localparam int SCALE_W   = 24;

    // Configuration port
    localparam int DATA_W    = 64;
    localparam int ADDR_W    = 6;
    localparam int REG_LSB   = 3;

    // Normalizer and divider widths
    localparam int NORM_W    = 31;
    localparam int SUM_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int REM_W     = ROOT_W + 3;
    localparam int QUO_W     = FRAC_BITS + 1;
    localparam int NUM_W     = NORM_W + FRAC_BITS + 1;

    // Pipeline depths
    localparam int VEC_LAT   = 12;
    localparam int SQRT_LAT  = ROOT_W;
    localparam int DIV_LAT   = QUO_W + 1;
    localparam int TOTAL_LAT = VEC_LAT + SQRT_LAT + DIV_LAT + 1;

    localparam logic [BASIS_W-1:0] BASIS_RESET = BASIS_W'(UNIT);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(UNIT);

    typedef enum logic [2:0] {
        REG_FORWARD = 3'd0,
        REG_RIGHT   = 3'd1,
        REG_UP      = 3'd2,
        REG_SCALE_X = 3'd3,
        REG_SCALE_Y = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [BASIS_W-1:0] fwd;
        logic [BASIS_W-1:0] rgt;
        logic [BASIS_W-1:0] upv;
        logic [SCALE_W-1:0] scale_x;
        logic [SCALE_W-1:0] scale_y;
    } t_cfg;

    typedef struct packed {
        logic [2:0]             neg;
        logic                   zero;
    } t_sign;

    typedef struct packed {
        logic [2:0][NORM_W-1:0] mag;
        t_sign                  sgn;
    } t_side;

endpackage

@@ rtl/crd_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crd_cfg
// APB register file holding the camera basis and the two screen scales.
// ----------------------------------------------------------------------------
module crd_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crd_pkg::ADDR_W-1:0]    paddr,
    input  logic [crd_pkg::DATA_W-1:0]    pwdata,
    output logic [crd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output crd_pkg::t_cfg                 o_cfg
);
    import crd_pkg::*;

    logic [BASIS_W-1:0] r_fwd;
    logic [BASIS_W-1:0] r_rgt;
    logic [BASIS_W-1:0] r_upv;
    logic [SCALE_W-1:0] r_scale_x;
    logic [SCALE_W-1:0] r_scale_y;
    t_reg_idx           s_idx;
    logic               s_wr;

    assign pready = 1'b1;
    assign s_idx  = t_reg_idx'(paddr[ADDR_W-1:REG_LSB]);
    assign s_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd     <= BASIS_RESET;
            r_rgt     <= BASIS_RESET;
            r_upv     <= BASIS_RESET;
            r_scale_x <= SCALE_RESET;
            r_scale_y <= SCALE_RESET;
        end else if (s_wr) begin
            case (s_idx)
                REG_FORWARD: r_fwd     <= pwdata[BASIS_W-1:0];
                REG_RIGHT:   r_rgt     <= pwdata[BASIS_W-1:0];
                REG_UP:      r_upv     <= pwdata[BASIS_W-1:0];
                REG_SCALE_X: r_scale_x <= pwdata[SCALE_W-1:0];
                REG_SCALE_Y: r_scale_y <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (s_idx)
            REG_FORWARD: prdata = DATA_W'(r_fwd);
            REG_RIGHT:   prdata = DATA_W'(r_rgt);
            REG_UP:      prdata = DATA_W'(r_upv);
            REG_SCALE_X: prdata = DATA_W'(r_scale_x);
            REG_SCALE_Y: prdata = DATA_W'(r_scale_y);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg.fwd     = r_fwd;
    assign o_cfg.rgt     = r_rgt;
    assign o_cfg.upv     = r_upv;
    assign o_cfg.scale_x = r_scale_x;
    assign o_cfg.scale_y = r_scale_y;

endmodule

@@ rtl/crd_vec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crd_vec
// Direction build pipeline: screen offsets, basis combination, magnitude,
// shared normalizing shift and sum of squares.
// ----------------------------------------------------------------------------
module crd_vec (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [crd_pkg::COORD_W-1:0]   i_u_coord,
    input  logic [crd_pkg::COORD_W-1:0]   i_v_coord,
    input  crd_pkg::t_cfg                 i_cfg,
    output logic                          o_valid,
    output logic [crd_pkg::SUM_W-1:0]     o_sum,
    output crd_pkg::t_side                o_side
);
    import crd_pkg::*;

    localparam int SX_W    = COORD_W + 2;
    localparam int PX_W    = SX_W + SCALE_W - 1;
    localparam int LO_W    = SCALE_W;
    localparam int PL_W    = LO_W + 1 + COMP_W;
    localparam int PH_W    = PX_W - LO_W + COMP_W;
    localparam int D_W     = 62;
    localparam int MAG_W   = 60;
    localparam int CHUNK_W = 16;
    localparam int NCHUNK  = 4;
    localparam int PAD_W   = CHUNK_W * NCHUNK;
    localparam int POS_W   = $clog2(PAD_W);
    localparam int ONE_SH  = COORD_W + FRAC_BITS;
    localparam int SQ_W    = 2 * NORM_W;

    function automatic logic [3:0] lead_zeros16(input logic [CHUNK_W-1:0] x);
        logic [3:0] n;
        logic       found;
        n     = 4'd0;
        found = 1'b0;
        for (int k = CHUNK_W - 1; k >= 0; k--) begin
            if (!found && !x[k]) begin
                n = n + 4'd1;
            end else begin
                found = 1'b1;
            end
        end
        return n;
    endfunction

    logic [VEC_LAT-1:0]       r_vld;

    logic signed [SX_W-1:0]   s_sx, s_sy;
    logic signed [COMP_W-1:0] s_fwd [3];
    logic signed [COMP_W-1:0] s_rgt [3];
    logic signed [COMP_W-1:0] s_upv [3];

    logic signed [PX_W+1:0]   n_px, n_py;
    logic signed [PX_W-1:0]   r_px1, r_py1;

    logic signed [PL_W-1:0]   n_plr [3], n_plu [3], r_plr2 [3], r_plu2 [3];
    logic signed [PH_W-1:0]   n_phr [3], n_phu [3], r_phr2 [3], r_phu2 [3];

    logic signed [D_W-1:0]    n_a [3], n_b [3], r_a3 [3], r_b3 [3];
    logic signed [D_W-1:0]    n_d [3], r_d4 [3];

    logic [MAG_W-1:0]         n_mag [3], r_mag5 [3], r_mag6 [3], r_mag7 [3], r_mag8 [3];
    logic [2:0]               r_neg5, r_neg6, r_neg7, r_neg8, r_neg9, r_neg10, r_neg11;
    logic [MAG_W-1:0]         n_top, r_top6;

    logic [PAD_W-1:0]         n_pad;
    logic [NCHUNK-1:0]        n_nz, r_nz7;
    logic [3:0]               n_lz [NCHUNK], r_lz7 [NCHUNK];

    logic                     n_zero, r_zero8, r_zero9, r_zero10, r_zero11;
    logic [POS_W-1:0]         n_pos, n_amt, r_amt8, r_amt9;
    logic                     n_right, r_right8, r_right9;

    logic [PAD_W-1:0]         n_crs [3], r_crs9 [3];
    logic [NORM_W-1:0]        n_norm [3], r_norm10 [3], r_norm11 [3];
    logic [SQ_W-1:0]          n_sq [3], r_sq11 [3];
    logic [SUM_W-1:0]         n_sum, r_sum12;
    t_side                    n_side, r_side12;

    // Screen offsets and camera basis lanes
    always_comb begin
        s_sx = $signed({1'b0, i_u_coord, 1'b0}) - $signed(SX_W'(1 << COORD_W));
        s_sy = $signed({1'b0, i_v_coord, 1'b0}) - $signed(SX_W'(1 << COORD_W));
        for (int i = 0; i < 3; i++) begin
            s_fwd[i] = $signed(i_cfg.fwd[i*COMP_W +: COMP_W]);
            s_rgt[i] = $signed(i_cfg.rgt[i*COMP_W +: COMP_W]);
            s_upv[i] = $signed(i_cfg.upv[i*COMP_W +: COMP_W]);
        end
    end

    always_comb begin
        n_px = s_sx * $signed({1'b0, i_cfg.scale_x});
        n_py = s_sy * $signed({1'b0, i_cfg.scale_y});

        // Split px, py at the scale width to keep each product small
        for (int i = 0; i < 3; i++) begin
            n_plr[i] = $signed({1'b0, r_px1[LO_W-1:0]}) * s_rgt[i];
            n_phr[i] = $signed(r_px1[PX_W-1:LO_W]) * s_rgt[i];
            n_plu[i] = $signed({1'b0, r_py1[LO_W-1:0]}) * s_upv[i];
            n_phu[i] = $signed(r_py1[PX_W-1:LO_W]) * s_upv[i];

            n_a[i] = (D_W'(r_phr2[i]) <<< LO_W) + D_W'(r_plr2[i]);
            n_b[i] = (D_W'(r_phu2[i]) <<< LO_W) + D_W'(r_plu2[i]);

            n_d[i] = r_a3[i] + r_b3[i] + (D_W'(s_fwd[i]) <<< ONE_SH);

            n_mag[i] = r_d4[i][D_W-1] ? MAG_W'(-r_d4[i]) : MAG_W'(r_d4[i]);
        end

        n_top = (r_mag5[0] > r_mag5[1]) ? r_mag5[0] : r_mag5[1];
        if (r_mag5[2] > n_top) begin
            n_top = r_mag5[2];
        end

        // Leading-one search, one chunk encoder per 16 bits
        n_pad = PAD_W'(r_top6);
        for (int c = 0; c < NCHUNK; c++) begin
            n_nz[c] = |n_pad[c*CHUNK_W +: CHUNK_W];
            n_lz[c] = lead_zeros16(n_pad[c*CHUNK_W +: CHUNK_W]);
        end

        // Highest nonzero chunk wins; shift puts the top at bit NORM_W-1
        n_zero = 1'b1;
        n_pos  = '0;
        for (int c = 0; c < NCHUNK; c++) begin
            if (r_nz7[c]) begin
                n_zero = 1'b0;
                n_pos  = {2'(c), ~r_lz7[c]};
            end
        end
        n_right = n_pos > POS_W'(NORM_W - 1);
        n_amt   = n_right ? n_pos - POS_W'(NORM_W - 1) : POS_W'(NORM_W - 1) - n_pos;

        for (int i = 0; i < 3; i++) begin
            n_crs[i]  = r_right8 ? (PAD_W'(r_mag8[i]) >> {r_amt8[POS_W-1:3], 3'b000})
                                 : (PAD_W'(r_mag8[i]) << {r_amt8[POS_W-1:3], 3'b000});
            n_norm[i] = NORM_W'(r_right9 ? (r_crs9[i] >> r_amt9[2:0])
                                         : (r_crs9[i] << r_amt9[2:0]));
            n_sq[i]   = r_norm10[i] * r_norm10[i];
        end

        n_sum = SUM_W'(r_sq11[0]) + SUM_W'(r_sq11[1]) + SUM_W'(r_sq11[2]);
        for (int i = 0; i < 3; i++) begin
            n_side.mag[i] = r_norm11[i];
        end
        n_side.sgn.neg  = r_neg11;
        n_side.sgn.zero = r_zero11;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[VEC_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_px1 <= n_px[PX_W-1:0];
        r_py1 <= n_py[PX_W-1:0];
        for (int i = 0; i < 3; i++) begin
            r_plr2[i]   <= n_plr[i];
            r_phr2[i]   <= n_phr[i];
            r_plu2[i]   <= n_plu[i];
            r_phu2[i]   <= n_phu[i];
            r_a3[i]     <= n_a[i];
            r_b3[i]     <= n_b[i];
            r_d4[i]     <= n_d[i];
            r_neg5[i]   <= r_d4[i][D_W-1];
            r_mag5[i]   <= n_mag[i];
            r_mag6[i]   <= r_mag5[i];
            r_mag7[i]   <= r_mag6[i];
            r_mag8[i]   <= r_mag7[i];
            r_crs9[i]   <= n_crs[i];
            r_norm10[i] <= n_norm[i];
            r_norm11[i] <= r_norm10[i];
            r_sq11[i]   <= n_sq[i];
        end
        for (int c = 0; c < NCHUNK; c++) begin
            r_lz7[c] <= n_lz[c];
        end
        r_top6   <= n_top;
        r_nz7    <= n_nz;
        r_neg6   <= r_neg5;
        r_neg7   <= r_neg6;
        r_neg8   <= r_neg7;
        r_neg9   <= r_neg8;
        r_neg10  <= r_neg9;
        r_neg11  <= r_neg10;
        r_zero8  <= n_zero;
        r_zero9  <= r_zero8;
        r_zero10 <= r_zero9;
        r_zero11 <= r_zero10;
        r_right8 <= n_right;
        r_amt8   <= n_amt;
        r_right9 <= r_right8;
        r_amt9   <= r_amt8;
        r_sum12  <= n_sum;
        r_side12 <= n_side;
    end

    assign o_valid = r_vld[VEC_LAT-1];
    assign o_sum   = r_sum12;
    assign o_side  = r_side12;

endmodule

@@ rtl/crd_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crd_sqrt
// Integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module crd_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [crd_pkg::SUM_W-1:0]     i_sum,
    input  crd_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [crd_pkg::ROOT_W-1:0]    o_root,
    output crd_pkg::t_side                o_side
);
    import crd_pkg::*;

    logic [ROOT_W-1:0] r_vld;
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SUM_W-1:0]  r_rad  [ROOT_W];
    t_side             r_side [ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ROOT_W-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [REM_W-1:0]  s_rem;
        logic [ROOT_W-1:0] s_root;
        logic [SUM_W-1:0]  s_rad;
        t_side             s_side;
        logic [REM_W-1:0]  n_cur;
        logic [REM_W-1:0]  n_trial;
        logic              n_ge;

        if (k == 0) begin : g_head
            assign s_rem  = '0;
            assign s_root = '0;
            assign s_rad  = i_sum;
            assign s_side = i_side;
        end else begin : g_body
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
            assign s_rad  = r_rad[k-1];
            assign s_side = r_side[k-1];
        end

        // Bring down two radicand bits, try root*4+1
        always_comb begin
            n_cur   = {s_rem[REM_W-3:0], s_rad[SUM_W-1 -: 2]};
            n_trial = REM_W'({s_root, 2'b01});
            n_ge    = n_cur >= n_trial;
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= n_ge ? n_cur - n_trial : n_cur;
            r_root[k] <= {s_root[ROOT_W-2:0], n_ge};
            r_rad[k]  <= s_rad << 2;
            r_side[k] <= s_side;
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

@@ rtl/crd_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crd_div
// Rounded division of the three normalized magnitudes by the root,
// one quotient bit per pipeline stage after a numerator stage, three lanes side by side.
// ----------------------------------------------------------------------------
module crd_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [crd_pkg::ROOT_W-1:0]          i_root,
    input  crd_pkg::t_side                      i_side,
    output logic                                o_valid,
    output logic [2:0][crd_pkg::QUO_W-1:0]      o_quo,
    output crd_pkg::t_sign                      o_sgn
);
    import crd_pkg::*;

    localparam int CMP_W = NUM_W + 1;

    logic                   r_vld0;
    logic [2:0][NUM_W-1:0]  r_num0;
    logic [ROOT_W-1:0]      r_den0;
    t_sign                  r_sgn0;
    logic [2:0][NUM_W-1:0]  n_num;

    logic [QUO_W-1:0]       r_vld;
    logic [2:0][NUM_W-1:0]  r_rem [QUO_W];
    logic [2:0][QUO_W-1:0]  r_quo [QUO_W];
    logic [ROOT_W-1:0]      r_den [QUO_W];
    t_sign                  r_sgn [QUO_W];

    // Numerator carries half the divisor for round to nearest
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = NUM_W'({i_side.mag[i], FRAC_BITS'(0)}) + NUM_W'(i_root >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld  <= '0;
        end else begin
            r_vld0 <= i_valid;
            r_vld  <= {r_vld[QUO_W-2:0], r_vld0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_num0 <= n_num;
        r_den0 <= i_root;
        r_sgn0 <= i_side.sgn;
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        localparam int B = QUO_W - 1 - j;
        logic [2:0][NUM_W-1:0] s_rem;
        logic [2:0][QUO_W-1:0] s_quo;
        logic [ROOT_W-1:0]     s_den;
        t_sign                 s_sgn;
        logic [CMP_W-1:0]      n_trial;
        logic [2:0][NUM_W-1:0] n_rem;
        logic [2:0][QUO_W-1:0] n_quo;
        logic [2:0]            n_ge;

        if (j == 0) begin : g_head
            assign s_rem = r_num0;
            assign s_quo = '0;
            assign s_den = r_den0;
            assign s_sgn = r_sgn0;
        end else begin : g_body
            assign s_rem = r_rem[j-1];
            assign s_quo = r_quo[j-1];
            assign s_den = r_den[j-1];
            assign s_sgn = r_sgn[j-1];
        end

        // Subtract the shifted divisor where it fits
        always_comb begin
            n_trial = CMP_W'(s_den) << B;
            for (int i = 0; i < 3; i++) begin
                n_ge[i]     = CMP_W'(s_rem[i]) >= n_trial;
                n_rem[i]    = n_ge[i] ? NUM_W'(CMP_W'(s_rem[i]) - n_trial) : s_rem[i];
                n_quo[i]    = s_quo[i];
                n_quo[i][B] = n_ge[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[j] <= n_rem;
            r_quo[j] <= n_quo;
            r_den[j] <= s_den;
            r_sgn[j] <= s_sgn;
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_sgn   = r_sgn[QUO_W-1];

endmodule

@@ rtl/camera_ray_direction_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_ray_direction_core
// Pinhole camera ray generator: screen coordinates in, unit ray direction out.
// ----------------------------------------------------------------------------
// The core takes one (u, v) screen coordinate pair in every clock cycle and
// returns the matching unit ray direction, signed Q1.16 per component.
// busy is never raised, so a new transfer may be issued on every cycle.
// Results are shown on o_dir_x/y/z for a single cycle, flagged by o_done;
// there is no backpressure, so the receiver must capture them in that cycle.
// Each pair passes through the 32-stage square root and the 18-stage
// quotient pipeline (one numerator stage and one stage per quotient bit)
// that normalize the vector, plus twelve stages that build the direction
// and its normalizing shift and one output stage. Program the basis vectors
// and scales through the APB port (64-bit data, register i at byte address
// 8*i) only while no ray is in flight; items read the registers as they
// travel down the pipeline. A zero direction yields an all-zero result,
// and components saturate to +/-1.0.
// ----------------------------------------------------------------------------
module camera_ray_direction_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [crd_pkg::COORD_W-1:0]          i_u_coord,
    input  logic [crd_pkg::COORD_W-1:0]          i_v_coord,
    output logic                                 o_done,
    output logic signed [crd_pkg::COMP_W-1:0]    o_dir_x,
    output logic signed [crd_pkg::COMP_W-1:0]    o_dir_y,
    output logic signed [crd_pkg::COMP_W-1:0]    o_dir_z,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [crd_pkg::ADDR_W-1:0]           paddr,
    input  logic [crd_pkg::DATA_W-1:0]           pwdata,
    output logic [crd_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);
    import crd_pkg::*;

    localparam logic signed [COMP_W-1:0] DIR_MAX = COMP_W'(UNIT);
    localparam logic signed [COMP_W-1:0] DIR_MIN = -DIR_MAX;

    t_cfg                   s_cfg;
    logic                   s_accept;

    logic                   s_vec_vld;
    logic [SUM_W-1:0]       s_vec_sum;
    t_side                  s_vec_side;

    logic                   s_sq_vld;
    logic [ROOT_W-1:0]      s_sq_root;
    t_side                  s_sq_side;

    logic                   s_div_vld;
    logic [2:0][QUO_W-1:0]  s_div_quo;
    t_sign                  s_div_sgn;

    logic [QUO_W-1:0]       n_q [3];
    logic signed [COMP_W-1:0] n_dir [3];
    logic signed [COMP_W-1:0] r_dir [3];
    logic                   r_done;

    // The pipeline never stalls, so every start is a transfer
    assign busy     = 1'b0;
    assign s_accept = start && !busy;

    crd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    // Build d = forward + px*right + py*up, normalize its scale, sum squares
    crd_vec u_vec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_accept),
        .i_u_coord (i_u_coord),
        .i_v_coord (i_v_coord),
        .i_cfg     (s_cfg),
        .o_valid   (s_vec_vld),
        .o_sum     (s_vec_sum),
        .o_side    (s_vec_side)
    );

    // Vector length
    crd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_vec_vld),
        .i_sum   (s_vec_sum),
        .i_side  (s_vec_side),
        .o_valid (s_sq_vld),
        .o_root  (s_sq_root),
        .o_side  (s_sq_side)
    );

    // Component / length, rounded to nearest
    crd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_sq_vld),
        .i_root  (s_sq_root),
        .i_side  (s_sq_side),
        .o_valid (s_div_vld),
        .o_quo   (s_div_quo),
        .o_sgn   (s_div_sgn)
    );

    // Clamp to 1.0, restore the sign, force zero for a null direction
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_q[i] = s_div_quo[i];
            if (n_q[i] > QUO_W'(UNIT)) begin
                n_q[i] = QUO_W'(UNIT);
            end
            if (s_div_sgn.zero) begin
                n_dir[i] = '0;
            end else if (s_div_sgn.neg[i]) begin
                n_dir[i] = -COMP_W'(n_q[i]);
            end else begin
                n_dir[i] = COMP_W'(n_q[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= s_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_dir[i] <= n_dir[i];
        end
    end

    assign o_done  = r_done;
    assign o_dir_x = r_dir[0];
    assign o_dir_y = r_dir[1];
    assign o_dir_z = r_dir[2];

    // Every accepted transfer comes out after the fixed latency
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |-> ##TOTAL_LAT o_done)
        else $error("accepted transfer produced no result");

    // No result without a matching transfer
    a_latency_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(s_accept, TOTAL_LAT))
        else $error("result without a matching transfer");

    // Components stay within unit range
    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_dir_x <= DIR_MAX) && (o_dir_x >= DIR_MIN)
                && (o_dir_y <= DIR_MAX) && (o_dir_y >= DIR_MIN)
                && (o_dir_z <= DIR_MAX) && (o_dir_z >= DIR_MIN))
        else $error("direction component out of range");

endmodule
